### src/gsp_pkg.sv
// Package for the gamepad select line poller.
// Sequencer phase codes, button bit positions, pin masks and shared types.
// No dependencies.
package gsp_pkg;

  localparam int CFG_W  = 16;
  localparam int PINS_W = 8;
  localparam int BTN_W  = 12;
  localparam int KIND_W = 2;
  localparam int PH_W   = 4;

  localparam logic [CFG_W-1:0] SETTLE_RST = 16'd1600;

  // sequencer phases
  localparam logic [PH_W-1:0] PH_IDLE = 4'd0;
  localparam logic [PH_W-1:0] PH_H1   = 4'd1;
  localparam logic [PH_W-1:0] PH_L1   = 4'd2;
  localparam logic [PH_W-1:0] PH_H2   = 4'd3;
  localparam logic [PH_W-1:0] PH_L2   = 4'd4;
  localparam logic [PH_W-1:0] PH_H3   = 4'd5;
  localparam logic [PH_W-1:0] PH_L3   = 4'd6;
  localparam logic [PH_W-1:0] PH_H4   = 4'd7;
  localparam logic [PH_W-1:0] PH_L4   = 4'd8;

  // pad kinds
  localparam logic [KIND_W-1:0] KIND_TWO   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_THREE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SIX   = 2'd2;

  // button bit positions
  localparam int BTN_UP    = 0;
  localparam int BTN_DOWN  = 1;
  localparam int BTN_LEFT  = 2;
  localparam int BTN_RIGHT = 3;
  localparam int BTN_A     = 4;
  localparam int BTN_B     = 5;
  localparam int BTN_C     = 6;
  localparam int BTN_START = 7;
  localparam int BTN_MODE  = 8;
  localparam int BTN_X     = 9;
  localparam int BTN_Y     = 10;
  localparam int BTN_Z     = 11;

  localparam logic [PINS_W-1:0] THREE_MASK = 8'h03;
  localparam logic [PINS_W-1:0] SIX_MASK   = 8'h0F;

  // sequencer state apart from the wait counter
  typedef struct packed {
    logic [PH_W-1:0]   phase;
    logic [BTN_W-1:0]  buttons;
    logic [KIND_W-1:0] kind;
    logic              sel;
  } gsp_ctl_t;

endpackage

### src/gsp_if.sv
// Valid/ready channel interfaces for the gamepad select line poller.
// Input word: poll request and pin levels. Result word: select, buttons, status.
// No dependencies.
interface gsp_in_if;
  logic       valid;
  logic       ready;
  logic       poll;
  logic [7:0] pins;

  modport source (output valid, output poll, output pins, input ready);
  modport sink   (input valid, input poll, input pins, output ready);
endinterface

interface gsp_out_if;
  logic        valid;
  logic        ready;
  logic        select_level;
  logic [11:0] buttons;
  logic [1:0]  pad_kind;
  logic        busy_res;
  logic        poll_done;

  modport source (output valid, output select_level, output buttons, output pad_kind,
                  output busy_res, output poll_done, input ready);
  modport sink   (input valid, input select_level, input buttons, input pad_kind,
                  input busy_res, input poll_done, output ready);
endinterface

### src/gsp_step.sv
// One tick of the select line sequencer: next state from current state and pins.
// Purely combinational; depends on gsp_pkg.
module gsp_step import gsp_pkg::*; #(
  parameter int WAIT_WIDTH = 16
) (
  input  gsp_ctl_t              ctl,
  input  logic [WAIT_WIDTH-1:0] wait_cnt,
  input  logic [WAIT_WIDTH-1:0] reload,
  input  logic                  poll,
  input  logic [PINS_W-1:0]     pins,
  output gsp_ctl_t              ctl_nxt,
  output logic [WAIT_WIDTH-1:0] wait_nxt,
  output logic                  done
);

  logic [PINS_W-1:0] prs;

  // a low pin is a pressed button
  assign prs = ~pins;

  always_comb begin
    ctl_nxt  = ctl;
    wait_nxt = wait_cnt;
    done     = 1'b0;
    if (ctl.phase == PH_IDLE) begin
      if (poll) begin
        ctl_nxt.sel   = 1'b1;
        ctl_nxt.phase = PH_H1;
        wait_nxt      = reload;
      end
    end else if (wait_cnt > WAIT_WIDTH'(1)) begin
      wait_nxt = wait_cnt - WAIT_WIDTH'(1);
    end else begin
      wait_nxt = '0;
      case (ctl.phase)
        PH_H1: begin
          ctl_nxt.buttons[BTN_RIGHT] = prs[0];
          ctl_nxt.buttons[BTN_LEFT]  = prs[1];
          ctl_nxt.buttons[BTN_DOWN]  = prs[2];
          ctl_nxt.buttons[BTN_UP]    = prs[3];
          ctl_nxt.buttons[BTN_C]     = prs[4];
          ctl_nxt.buttons[BTN_B]     = prs[6];
          ctl_nxt.sel   = 1'b0;
          ctl_nxt.phase = PH_L1;
          wait_nxt      = reload;
        end
        PH_L1: begin
          if ((pins & THREE_MASK) == '0) begin
            ctl_nxt.buttons[BTN_START] = prs[4];
            ctl_nxt.buttons[BTN_A]     = prs[6];
            ctl_nxt.sel   = 1'b1;
            ctl_nxt.phase = PH_H2;
            wait_nxt      = reload;
          end else begin
            // shift B and C down onto A and B
            ctl_nxt.buttons[BTN_A] = ctl.buttons[BTN_B];
            ctl_nxt.buttons[BTN_B] = ctl.buttons[BTN_C];
            ctl_nxt.buttons[BTN_C] = 1'b0;
            ctl_nxt.kind  = KIND_TWO;
            ctl_nxt.phase = PH_IDLE;
            done          = 1'b1;
          end
        end
        PH_H2: begin
          ctl_nxt.sel   = 1'b0;
          ctl_nxt.phase = PH_L2;
          wait_nxt      = reload;
        end
        PH_L2: begin
          ctl_nxt.sel   = 1'b1;
          ctl_nxt.phase = PH_H3;
          wait_nxt      = reload;
        end
        PH_H3: begin
          ctl_nxt.sel   = 1'b0;
          ctl_nxt.phase = PH_L3;
          wait_nxt      = reload;
        end
        PH_L3: begin
          if ((pins & SIX_MASK) == '0) begin
            ctl_nxt.kind  = KIND_SIX;
            ctl_nxt.sel   = 1'b1;
            ctl_nxt.phase = PH_H4;
            wait_nxt      = reload;
          end else begin
            ctl_nxt.kind  = KIND_THREE;
            ctl_nxt.phase = PH_IDLE;
            done          = 1'b1;
          end
        end
        PH_H4: begin
          ctl_nxt.buttons[BTN_MODE] = prs[0];
          ctl_nxt.buttons[BTN_X]    = prs[1];
          ctl_nxt.buttons[BTN_Y]    = prs[2];
          ctl_nxt.buttons[BTN_Z]    = prs[3];
          ctl_nxt.sel   = 1'b0;
          ctl_nxt.phase = PH_L4;
          wait_nxt      = reload;
        end
        PH_L4: begin
          ctl_nxt.phase = PH_IDLE;
          done          = 1'b1;
        end
        default: begin
          ctl_nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

### src/gamepad_select_line_poller.sv
// Gamepad select line poller: one input word is one sequencer tick.
// A word waits in the input register, then moves into the result register
// when that is empty or read; one word per cycle unless the result side stalls,
// set by the single step unit between them. Synchronous active-low reset:
// sequencer idle, select high, buttons released, settle time 1600 ticks.
module gamepad_select_line_poller import gsp_pkg::*; #(
  parameter int WAIT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  gsp_in_if.sink             in_ch,
  gsp_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int EXT_W = (WAIT_WIDTH > CFG_W) ? WAIT_WIDTH : CFG_W;

  logic [CFG_W-1:0]      settle_r;
  logic                  in_valid_r;
  logic                  in_poll_r;
  logic [PINS_W-1:0]     in_pins_r;
  gsp_ctl_t              ctl_r;
  gsp_ctl_t              ctl_nxt;
  logic [WAIT_WIDTH-1:0] wait_r;
  logic [WAIT_WIDTH-1:0] wait_nxt;
  logic                  done_nxt;
  logic                  out_valid_r;
  logic                  out_done_r;
  logic                  advance;
  logic [EXT_W-1:0]      settle_ext;
  logic [EXT_W-1:0]      wait_max;
  logic [WAIT_WIDTH-1:0] reload;

  // saturate the settle time to what the wait counter holds
  assign settle_ext = EXT_W'(settle_r);
  assign wait_max   = EXT_W'({WAIT_WIDTH{1'b1}});
  assign reload     = (settle_ext > wait_max) ? WAIT_WIDTH'(wait_max)
                                              : WAIT_WIDTH'(settle_ext);

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  gsp_step #(.WAIT_WIDTH(WAIT_WIDTH)) u_step (
    .ctl      (ctl_r),
    .wait_cnt (wait_r),
    .reload   (reload),
    .poll     (in_poll_r),
    .pins     (in_pins_r),
    .ctl_nxt  (ctl_nxt),
    .wait_nxt (wait_nxt),
    .done     (done_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_RST;
    end else if (cfg_we) begin
      settle_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_poll_r <= in_ch.poll;
      in_pins_r <= in_ch.pins;
    end
  end

  // advance the sequencer once per word moved into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase   <= PH_IDLE;
      ctl_r.buttons <= '0;
      ctl_r.kind    <= KIND_TWO;
      ctl_r.sel     <= 1'b1;
      wait_r        <= '0;
      out_valid_r   <= 1'b0;
      out_done_r    <= 1'b0;
    end else begin
      if (advance) begin
        ctl_r      <= ctl_nxt;
        wait_r     <= wait_nxt;
        out_done_r <= done_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.select_level = ctl_r.sel;
  assign out_ch.buttons      = ctl_r.buttons;
  assign out_ch.pad_kind     = ctl_r.kind;
  assign out_ch.busy_res     = (ctl_r.phase != PH_IDLE);
  assign out_ch.poll_done    = out_done_r;

endmodule

### src/gsp_chk.sv
// Port-level checks for the gamepad select line poller.
// Bound to gamepad_select_line_poller; depends on its channel ports only.
module gsp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        select_level,
  input logic [11:0] buttons,
  input logic [1:0]  pad_kind,
  input logic        busy_res,
  input logic        poll_done
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(buttons) && $stable(pad_kind)
      && $stable(select_level) && $stable(busy_res) && $stable(poll_done))
    else $error("result word changed while stalled");

  // a finishing word never reports busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && poll_done |-> !busy_res)
    else $error("poll_done with busy_res set");

  // pad kind is one of the three kinds
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pad_kind != 2'd3)
    else $error("illegal pad kind");

  // an empty result slot never blocks the input side
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result slot");

endmodule

bind gamepad_select_line_poller gsp_chk u_gsp_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .select_level (out_ch.select_level),
  .buttons      (out_ch.buttons),
  .pad_kind     (out_ch.pad_kind),
  .busy_res     (out_ch.busy_res),
  .poll_done    (out_ch.poll_done)
);
